>>> design/hbci_segment_tokenizer_unit_macros.svh
// assertion helpers for the tokenizer top module
`ifndef HBCI_SEGMENT_TOKENIZER_UNIT_MACROS_SVH
`define HBCI_SEGMENT_TOKENIZER_UNIT_MACROS_SVH

// same-cycle implication
`define HBST_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hbst assertion failed");

// next-cycle implication
`define HBST_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hbst assertion failed");

`endif

>>> design/hbst_pkg.sv
package hbst_pkg;

   localparam int LEN_WIDTH   = 24;
   localparam int INDEX_WIDTH = 8;
   localparam int SEG_WIDTH   = 16;
   localparam int CNT_WIDTH   = 24;
   localparam int HDR_WIDTH   = 16;
   localparam int HDR_COUNT   = 3;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_WIDTH  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   localparam logic [LEN_WIDTH-1:0]   LEN_MAX = '1;
   localparam logic [INDEX_WIDTH-1:0] IDX_MAX = '1;
   localparam logic [SEG_WIDTH-1:0]   SEG_MAX = '1;
   localparam logic [CNT_WIDTH-1:0]   CNT_MAX = '1;
   localparam logic [HDR_WIDTH-1:0]   HDR_MAX = '1;

   localparam logic [7:0] CHR_QUOTE = 8'h27;
   localparam logic [7:0] CHR_PLUS  = 8'h2b;
   localparam logic [7:0] CHR_COLON = 8'h3a;
   localparam logic [7:0] CHR_QUEST = 8'h3f;
   localparam logic [7:0] CHR_AT    = 8'h40;
   localparam logic [7:0] CHR_ZERO  = 8'h30;
   localparam logic [7:0] CHR_NINE  = 8'h39;
   localparam logic [7:0] CHR_NUL   = 8'h00;

   typedef enum logic [2:0] {
      CLS_COLON,
      CLS_PLUS,
      CLS_QUOTE,
      CLS_NUL,
      CLS_QUEST,
      CLS_AT,
      CLS_DIGIT,
      CLS_OTHER
   } hbst_class_type;

   typedef enum logic [2:0] {
      MODE_BOUND,
      MODE_START,
      MODE_TEXT,
      MODE_ESC,
      MODE_BLEN,
      MODE_BDATA,
      MODE_ABIN,
      MODE_HALT
   } hbst_mode_type;

   typedef enum logic [3:0] {
      EV_TEXT  = 4'd0,
      EV_BIN   = 4'd1,
      EV_ELEM  = 4'd2,
      EV_GROUP = 4'd3,
      EV_SEG   = 4'd4,
      EV_MARK  = 4'd5,
      EV_OK    = 4'd6,
      EV_ERR   = 4'd7,
      EV_IGN   = 4'd8
   } hbst_event_type;

   typedef enum logic [2:0] {
      ERR_NONE    = 3'd0,
      ERR_ESC_END = 3'd1,
      ERR_NO_DELIM = 3'd2,
      ERR_BAD_LEN = 3'd3,
      ERR_BAD_BYTE = 3'd4
   } hbst_error_type;

   typedef struct packed {
      logic [7:0]     data;
      logic           last;
      hbst_class_type cls;
      logic [3:0]     digit;
   } hbst_token_type;

   typedef struct packed {
      hbst_event_type                        event_res;
      logic [7:0]                            out_byte;
      logic [SEG_WIDTH-1:0]                  segment_index;
      logic [7:0]                            group_index;
      logic [7:0]                            element_index;
      hbst_error_type                        error_code;
      logic [HDR_COUNT-1:0][HDR_WIDTH-1:0]   hdr;
      logic [CNT_WIDTH-1:0]                  consumed;
   } hbst_result_type;

   function automatic hbst_class_type hbst_classify(input logic [7:0] b);
      hbst_class_type c;
      c = CLS_OTHER;
      if (b == CHR_COLON) c = CLS_COLON;
      else if (b == CHR_PLUS) c = CLS_PLUS;
      else if (b == CHR_QUOTE) c = CLS_QUOTE;
      else if (b == CHR_NUL) c = CLS_NUL;
      else if (b == CHR_QUEST) c = CLS_QUEST;
      else if (b == CHR_AT) c = CLS_AT;
      else if (b >= CHR_ZERO && b <= CHR_NINE) c = CLS_DIGIT;
      return c;
   endfunction

endpackage

>>> design/hbci_segment_tokenizer_unit.sv
// a byte taken into the token queue is decoded from the queue head by the back end, and its
// event is registered into the result queue, which then clears empty for the pop side
// throughput: one byte per cycle as long as the result queue has room; a full result queue stalls the back end
// a two-entry token queue and a two-entry result queue decouple push from pop
// reset: synchronous, active high; empties both queues and returns the parser to
// a segment boundary with all counters and header values cleared
`include "hbci_segment_tokenizer_unit_macros.svh"

module hbci_segment_tokenizer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   input  logic        push,
   output logic        full,
   output logic [3:0]  rsp_event_res,
   output logic [7:0]  rsp_out_byte,
   output logic [15:0] rsp_segment_index,
   output logic [7:0]  rsp_group_index,
   output logic [7:0]  rsp_element_index,
   output logic [2:0]  rsp_error_code,
   output logic [15:0] rsp_seg_number,
   output logic [15:0] rsp_seg_version,
   output logic [15:0] rsp_ref_number,
   output logic [23:0] rsp_consumed,
   output logic        empty,
   input  logic        pop
);
   import hbst_pkg::*;

   hbst_token_type  tok_head;
   logic            tok_valid;
   logic            tok_take;
   hbst_result_type res;
   logic            res_push;
   logic            res_full;
   hbst_result_type rsp_head;

   hbst_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .push          (push),
      .full          (full),
      .tok_head      (tok_head),
      .tok_valid     (tok_valid),
      .tok_take      (tok_take)
   );

   hbst_back u_back (
      .clock     (clock),
      .reset     (reset),
      .tok_head  (tok_head),
      .tok_valid (tok_valid),
      .tok_take  (tok_take),
      .res       (res),
      .res_push  (res_push),
      .res_full  (res_full)
   );

   hbst_out_queue u_out_queue (
      .clock    (clock),
      .reset    (reset),
      .res      (res),
      .res_push (res_push),
      .res_full (res_full),
      .rsp_head (rsp_head),
      .empty    (empty),
      .pop      (pop)
   );

   assign rsp_event_res     = rsp_head.event_res;
   assign rsp_out_byte      = rsp_head.out_byte;
   assign rsp_segment_index = rsp_head.segment_index;
   assign rsp_group_index   = rsp_head.group_index;
   assign rsp_element_index = rsp_head.element_index;
   assign rsp_error_code    = rsp_head.error_code;
   assign rsp_seg_number    = rsp_head.hdr[0];
   assign rsp_seg_version   = rsp_head.hdr[1];
   assign rsp_ref_number    = rsp_head.hdr[2];
   assign rsp_consumed      = rsp_head.consumed;

   `HBST_ASSERT_NEXT(a_reset_empties, clock, 1'b0, reset, empty)
   `HBST_ASSERT_NOW(a_err_code_pairs, clock, reset, !empty, (rsp_event_res == EV_ERR) == (rsp_error_code != ERR_NONE))
   `HBST_ASSERT_NOW(a_consumed_only_ok, clock, reset, !empty && rsp_event_res != EV_OK, rsp_consumed == '0)
   `HBST_ASSERT_NOW(a_byte_only_payload, clock, reset, !empty && rsp_event_res != EV_TEXT && rsp_event_res != EV_BIN, rsp_out_byte == '0)

endmodule

>>> design/hbst_front.sv
module hbst_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [7:0]              req_data_byte,
   input  logic                    req_last_byte,
   input  logic                    push,
   output logic                    full,
   output hbst_pkg::hbst_token_type tok_head,
   output logic                    tok_valid,
   input  logic                    tok_take
);
   import hbst_pkg::*;

   hbst_token_type          slot_ff [QUEUE_DEPTH];
   hbst_token_type          slot_in;
   logic [QPTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_WIDTH-1:0]   count_ff, count_in;
   logic                    wr_en;
   logic                    rd_en;
   logic [7:0]              digit_off;

   assign full      = (count_ff == QCNT_WIDTH'(QUEUE_DEPTH));
   assign tok_valid = (count_ff != '0);
   assign tok_head  = slot_ff[rd_ptr_ff];
   assign wr_en     = push && !full;
   assign rd_en     = tok_take && tok_valid;

   // classify at the door so the back end decodes a class code rather than the raw byte
   assign digit_off = req_data_byte - CHR_ZERO;
   always_comb begin
      slot_in.data  = req_data_byte;
      slot_in.last  = req_last_byte;
      slot_in.cls   = hbst_classify(req_data_byte);
      slot_in.digit = digit_off[3:0];
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_en && !rd_en) count_in = count_ff + 1'b1;
      else if (rd_en && !wr_en) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wr_ptr_ff] <= slot_in;
      end
   end

endmodule

>>> design/hbst_back.sv
module hbst_back (
   input  logic                      clock,
   input  logic                      reset,
   input  hbst_pkg::hbst_token_type  tok_head,
   input  logic                      tok_valid,
   output logic                      tok_take,
   output hbst_pkg::hbst_result_type res,
   output logic                      res_push,
   input  logic                      res_full
);
   import hbst_pkg::*;

   hbst_mode_type                       mode_ff, mode_in;
   logic [LEN_WIDTH-1:0]                bin_rem_ff, bin_rem_in;
   logic [LEN_WIDTH-1:0]                bin_len_ff, bin_len_in;
   logic [SEG_WIDTH-1:0]                seg_cnt_ff, seg_cnt_in;
   logic [INDEX_WIDTH-1:0]              grp_cnt_ff, grp_cnt_in;
   logic [INDEX_WIDTH-1:0]              elm_cnt_ff, elm_cnt_in;
   logic [HDR_WIDTH-1:0]                hdr_acc_ff, hdr_acc_in;
   logic [HDR_COUNT-1:0][HDR_WIDTH-1:0] hdr_val_ff, hdr_val_in;
   logic [CNT_WIDTH-1:0]                byte_cnt_ff, byte_cnt_in;

   logic                                fire;
   logic                                hdr_slot;
   logic [HDR_COUNT-1:0][HDR_WIDTH-1:0] hdr_close;
   logic [HDR_WIDTH+3:0]                hdr_wide;
   logic [HDR_WIDTH-1:0]                hdr_digit;
   logic [LEN_WIDTH+3:0]                len_wide;
   logic [LEN_WIDTH-1:0]                len_digit;
   logic [LEN_WIDTH-1:0]                rem_dec;
   logic [INDEX_WIDTH-1:0]              elm_inc;
   logic [INDEX_WIDTH-1:0]              grp_inc;
   logic [CNT_WIDTH-1:0]                byte_inc;

   hbst_event_type                      ev;
   hbst_error_type                      err;
   logic [7:0]                          ob;
   logic [CNT_WIDTH-1:0]                cons;
   logic [HDR_COUNT-1:0][HDR_WIDTH-1:0] hv;
   logic                                counts;

   assign fire     = tok_valid && !res_full;
   assign tok_take = fire;
   assign res_push = fire;

   // header elements two to four live in group 0
   assign hdr_slot = (grp_cnt_ff == '0) && (elm_cnt_ff >= INDEX_WIDTH'(1))
                     && (elm_cnt_ff <= INDEX_WIDTH'(HDR_COUNT));

   always_comb begin
      for (int i = 0; i < HDR_COUNT; i++) begin
         hdr_close[i] = (hdr_slot && elm_cnt_ff == INDEX_WIDTH'(i + 1)) ? hdr_acc_ff
                                                                       : hdr_val_ff[i];
      end
   end

   assign hdr_wide  = (HDR_WIDTH+4)'(hdr_acc_ff) * (HDR_WIDTH+4)'(10)
                      + (HDR_WIDTH+4)'(tok_head.digit);
   assign hdr_digit = (hdr_wide > (HDR_WIDTH+4)'(HDR_MAX)) ? HDR_MAX
                                                            : hdr_wide[HDR_WIDTH-1:0];
   assign len_wide  = (LEN_WIDTH+4)'(bin_len_ff) * (LEN_WIDTH+4)'(10)
                      + (LEN_WIDTH+4)'(tok_head.digit);
   assign len_digit = (len_wide > (LEN_WIDTH+4)'(LEN_MAX)) ? LEN_MAX
                                                            : len_wide[LEN_WIDTH-1:0];
   assign rem_dec   = (bin_rem_ff != '0) ? bin_rem_ff - 1'b1 : bin_rem_ff;
   assign elm_inc   = (elm_cnt_ff == IDX_MAX) ? elm_cnt_ff : elm_cnt_ff + 1'b1;
   assign grp_inc   = (grp_cnt_ff == IDX_MAX) ? grp_cnt_ff : grp_cnt_ff + 1'b1;
   assign byte_inc  = (byte_cnt_ff == CNT_MAX) ? byte_cnt_ff : byte_cnt_ff + 1'b1;

   always_comb begin
      mode_in     = mode_ff;
      bin_rem_in  = bin_rem_ff;
      bin_len_in  = bin_len_ff;
      seg_cnt_in  = seg_cnt_ff;
      grp_cnt_in  = grp_cnt_ff;
      elm_cnt_in  = elm_cnt_ff;
      hdr_acc_in  = hdr_acc_ff;
      hdr_val_in  = hdr_val_ff;
      byte_cnt_in = byte_cnt_ff;
      ev          = EV_IGN;
      err         = ERR_NONE;
      ob          = '0;
      cons        = '0;
      hv          = '0;
      counts      = 1'b1;

      unique case (mode_ff)
         MODE_HALT: begin
            counts = 1'b0;
         end
         MODE_BDATA: begin
            ev         = EV_BIN;
            ob         = tok_head.data;
            bin_rem_in = rem_dec;
            if (tok_head.last) begin
               err = (rem_dec != '0) ? ERR_BAD_LEN : ERR_NO_DELIM;
            end else if (rem_dec == '0) begin
               mode_in = MODE_ABIN;
            end
         end
         MODE_ESC: begin
            if (tok_head.cls == CLS_NUL) begin
               err = ERR_ESC_END;
            end else begin
               ev      = EV_TEXT;
               ob      = tok_head.data;
               mode_in = MODE_TEXT;
               if (tok_head.cls == CLS_DIGIT && hdr_slot) hdr_acc_in = hdr_digit;
               if (tok_head.last) err = ERR_NO_DELIM;
            end
         end
         MODE_BLEN: begin
            if (tok_head.cls == CLS_DIGIT) begin
               ev         = EV_MARK;
               bin_len_in = len_digit;
               if (tok_head.last) err = ERR_BAD_LEN;
            end else if (tok_head.cls == CLS_AT) begin
               ev         = EV_MARK;
               bin_len_in = '0;
               if (tok_head.last) begin
                  err = (bin_len_ff != '0) ? ERR_BAD_LEN : ERR_NO_DELIM;
               end else if (bin_len_ff != '0) begin
                  bin_rem_in = bin_len_ff;
                  mode_in    = MODE_BDATA;
               end else begin
                  mode_in = MODE_ABIN;
               end
            end else begin
               err = ERR_BAD_LEN;
            end
         end
         MODE_BOUND, MODE_START, MODE_TEXT, MODE_ABIN: begin
            priority if (tok_head.cls == CLS_COLON) begin
               ev         = EV_ELEM;
               hdr_val_in = hdr_close;
               hdr_acc_in = '0;
               elm_cnt_in = elm_inc;
               mode_in    = MODE_START;
               if (tok_head.last) err = ERR_NO_DELIM;
            end else if (tok_head.cls == CLS_PLUS) begin
               ev         = EV_GROUP;
               hdr_val_in = hdr_close;
               hdr_acc_in = '0;
               grp_cnt_in = grp_inc;
               elm_cnt_in = '0;
               mode_in    = MODE_START;
               if (tok_head.last) err = ERR_NO_DELIM;
            end else if (tok_head.cls == CLS_QUOTE) begin
               hv         = hdr_close;
               hdr_val_in = '0;
               hdr_acc_in = '0;
               seg_cnt_in = (seg_cnt_ff == SEG_MAX) ? seg_cnt_ff : seg_cnt_ff + 1'b1;
               grp_cnt_in = '0;
               elm_cnt_in = '0;
               mode_in    = MODE_BOUND;
               if (tok_head.last) begin
                  ev   = EV_OK;
                  cons = byte_inc;
               end else begin
                  ev = EV_SEG;
               end
            end else if (mode_ff == MODE_ABIN) begin
               err = ERR_BAD_BYTE;
            end else if (tok_head.cls == CLS_NUL) begin
               if (mode_ff == MODE_BOUND) begin
                  // early message end: halt without counting the zero byte
                  ev      = EV_OK;
                  cons    = byte_cnt_ff;
                  mode_in = MODE_HALT;
                  counts  = 1'b0;
               end else begin
                  err = ERR_NO_DELIM;
               end
            end else if (tok_head.cls == CLS_QUEST) begin
               ev      = EV_MARK;
               mode_in = MODE_ESC;
               if (tok_head.last) err = ERR_ESC_END;
            end else if (tok_head.cls == CLS_AT && mode_ff != MODE_TEXT) begin
               ev         = EV_MARK;
               bin_len_in = '0;
               mode_in    = MODE_BLEN;
               if (tok_head.last) err = ERR_BAD_LEN;
            end else begin
               ev      = EV_TEXT;
               ob      = tok_head.data;
               mode_in = MODE_TEXT;
               if (tok_head.cls == CLS_DIGIT && hdr_slot) hdr_acc_in = hdr_digit;
               if (tok_head.last) err = ERR_NO_DELIM;
            end
         end
      endcase

      if (err != ERR_NONE) begin
         ev      = EV_ERR;
         ob      = '0;
         cons    = '0;
         hv      = '0;
         mode_in = MODE_HALT;
      end else if (counts) begin
         byte_cnt_in = byte_inc;
      end

      // final byte of the buffer returns everything to the idle values
      if (tok_head.last) begin
         mode_in     = MODE_BOUND;
         bin_rem_in  = '0;
         bin_len_in  = '0;
         seg_cnt_in  = '0;
         grp_cnt_in  = '0;
         elm_cnt_in  = '0;
         hdr_acc_in  = '0;
         hdr_val_in  = '0;
         byte_cnt_in = '0;
      end

      res.event_res     = ev;
      res.out_byte      = ob;
      res.segment_index = seg_cnt_ff;
      res.group_index   = 8'(grp_cnt_ff);
      res.element_index = 8'(elm_cnt_ff);
      res.error_code    = err;
      res.hdr           = hv;
      res.consumed      = cons;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_BOUND;
         bin_rem_ff  <= '0;
         bin_len_ff  <= '0;
         seg_cnt_ff  <= '0;
         grp_cnt_ff  <= '0;
         elm_cnt_ff  <= '0;
         hdr_acc_ff  <= '0;
         hdr_val_ff  <= '0;
         byte_cnt_ff <= '0;
      end else if (fire) begin
         mode_ff     <= mode_in;
         bin_rem_ff  <= bin_rem_in;
         bin_len_ff  <= bin_len_in;
         seg_cnt_ff  <= seg_cnt_in;
         grp_cnt_ff  <= grp_cnt_in;
         elm_cnt_ff  <= elm_cnt_in;
         hdr_acc_ff  <= hdr_acc_in;
         hdr_val_ff  <= hdr_val_in;
         byte_cnt_ff <= byte_cnt_in;
      end
   end

endmodule

>>> design/hbst_out_queue.sv
module hbst_out_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  hbst_pkg::hbst_result_type res,
   input  logic                      res_push,
   output logic                      res_full,
   output hbst_pkg::hbst_result_type rsp_head,
   output logic                      empty,
   input  logic                      pop
);
   import hbst_pkg::*;

   hbst_result_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_WIDTH-1:0]   count_ff, count_in;
   logic                    wr_en;
   logic                    rd_en;

   assign res_full = (count_ff == QCNT_WIDTH'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign rsp_head = slot_ff[rd_ptr_ff];
   assign wr_en    = res_push && !res_full;
   assign rd_en    = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_en && !rd_en) count_in = count_ff + 1'b1;
      else if (rd_en && !wr_en) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wr_ptr_ff] <= res;
      end
   end

endmodule
